### src/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared widths, register codes and types of the separable binomial blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sbb_pkg;

	localparam int PIX_W        = 8;
	localparam int SUM_W        = 12;
	localparam int ACC_W        = 17;
	localparam int MAX_CHANNELS = 4;
	localparam int WIN_DEPTH    = 4 * MAX_CHANNELS;
	localparam int WIN_IDX_W    = $clog2(WIN_DEPTH);
	localparam int FILL_W       = $clog2(WIN_DEPTH + 1);
	localparam int CFG_CH_W     = 3;
	localparam int ECH_W        = $clog2(MAX_CHANNELS + 1);
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 3;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_CHAN = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [ECH_W-1:0] chan_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		sum_t              tap1;
		sum_t              tap2;
		sum_t              tap3;
		sum_t              tap4;
	} win_view_t;

endpackage

`default_nettype wire

### src/sbb_col_sum.sv
// ----------------------------------------------------------------------------
// sbb_col_sum
// Vertical pass: weighted sum of one column of five elements, or of the middle three in 3-tap mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_col_sum (
	input  wire logic          five_tap,
	input  wire sbb_pkg::pix_t p0,
	input  wire sbb_pkg::pix_t p1,
	input  wire sbb_pkg::pix_t p2,
	input  wire sbb_pkg::pix_t p3,
	input  wire sbb_pkg::pix_t p4,
	output sbb_pkg::sum_t      sum
);

	sbb_pkg::sum_t e0, e1, e2, e3, e4;

	assign e0 = sbb_pkg::SUM_W'(p0);
	assign e1 = sbb_pkg::SUM_W'(p1);
	assign e2 = sbb_pkg::SUM_W'(p2);
	assign e3 = sbb_pkg::SUM_W'(p3);
	assign e4 = sbb_pkg::SUM_W'(p4);

	always_comb begin
		if (five_tap) begin
			sum = e0 + e4 + ((e1 + e3) << 2) + (e2 << 2) + (e2 << 1);
		end else begin
			sum = e1 + (e2 << 1) + e3;
		end
	end

endmodule

`default_nettype wire

### src/sbb_window.sv
// ----------------------------------------------------------------------------
// sbb_window
// Shift line of past column sums with fill count and channel-spaced taps.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_window (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic                row_start,
	input  wire sbb_pkg::sum_t       sum,
	input  wire sbb_pkg::chan_t      chan,
	output sbb_pkg::win_view_t       view
);

	sbb_pkg::sum_t                   win_q [sbb_pkg::WIN_DEPTH];
	logic [sbb_pkg::FILL_W-1:0]      fill_q;
	logic [sbb_pkg::FILL_W-1:0]      fill_base;

	assign fill_base = row_start ? '0 : fill_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q[0] <= sum;
			for (int i = 1; i < sbb_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= row_start ? '0 : win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (advance) begin
			if (int'(fill_base) < sbb_pkg::WIN_DEPTH) begin
				fill_q <= fill_base + 1'b1;
			end else begin
				fill_q <= fill_base;
			end
		end
	end

	always_comb begin
		view.fill = fill_base;
		view.tap1 = '0;
		view.tap2 = '0;
		view.tap3 = '0;
		view.tap4 = '0;
		for (int i = 1; i <= sbb_pkg::MAX_CHANNELS; i++) begin
			if (int'(chan) == i) begin
				view.tap1 = win_q[sbb_pkg::WIN_IDX_W'(i - 1)];
				view.tap2 = win_q[sbb_pkg::WIN_IDX_W'(2 * i - 1)];
				view.tap3 = win_q[sbb_pkg::WIN_IDX_W'(3 * i - 1)];
				view.tap4 = win_q[sbb_pkg::WIN_IDX_W'(4 * i - 1)];
			end
		end
	end

endmodule

`default_nettype wire

### src/sbb_hpass.sv
// ----------------------------------------------------------------------------
// sbb_hpass
// Horizontal pass: weights the taps, rounds, saturates and flags a full window.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_hpass (
	input  wire logic               five_tap,
	input  wire sbb_pkg::chan_t     chan,
	input  wire sbb_pkg::sum_t      sum,
	input  wire sbb_pkg::win_view_t view,
	output logic                    full,
	output sbb_pkg::pix_t           value
);

	logic [sbb_pkg::ACC_W-1:0] s0, s1, s2, s3, s4;
	logic [sbb_pkg::ACC_W-1:0] acc;
	logic [sbb_pkg::ACC_W-1:0] scaled;

	assign s0 = sbb_pkg::ACC_W'(sum);
	assign s1 = sbb_pkg::ACC_W'(view.tap1);
	assign s2 = sbb_pkg::ACC_W'(view.tap2);
	assign s3 = sbb_pkg::ACC_W'(view.tap3);
	assign s4 = sbb_pkg::ACC_W'(view.tap4);

	always_comb begin
		if (five_tap) begin
			full   = int'(view.fill) >= 4 * int'(chan);
			acc    = s0 + ((s1 + s3) << 2) + (s2 << 2) + (s2 << 1) + s4
				+ sbb_pkg::ACC_W'(128);
			scaled = acc >> 8;
		end else begin
			full   = int'(view.fill) >= 2 * int'(chan);
			acc    = s0 + (s1 << 1) + s2 + sbb_pkg::ACC_W'(8);
			scaled = acc >> 4;
		end
		if (scaled > sbb_pkg::ACC_W'(255)) begin
			value = '1;
		end else begin
			value = scaled[sbb_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

### src/separable_binomial_blur.sv
// ----------------------------------------------------------------------------
// separable_binomial_blur
// Streaming 3x3 / 5x5 binomial blur of interleaved 8-bit pixel columns.
// ----------------------------------------------------------------------------
// Takes one border-padded column of five elements per clock and returns one
// blurred element per column once the horizontal window is full (2*c columns
// after a row start in 3-tap mode, 4*c in 5-tap mode, c = channel count
// clamped to 1..4). Throughput is one column per cycle unless a stalled
// result holds the input register, so at most two requests are in flight. A
// request passes through the input register and then the result register
// around the vertical and horizontal passes. Write the mode and channel
// registers only while the block is idle.
`default_nettype none

module separable_binomial_blur (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sbb_pkg::APB_AW-1:0]  paddr,
	input  wire logic [sbb_pkg::APB_DW-1:0]  pwdata,
	output logic      [sbb_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire sbb_pkg::pix_t               pix_row0,
	input  wire sbb_pkg::pix_t               pix_row1,
	input  wire sbb_pkg::pix_t               pix_row2,
	input  wire sbb_pkg::pix_t               pix_row3,
	input  wire sbb_pkg::pix_t               pix_row4,
	input  wire logic                        row_start,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output sbb_pkg::pix_t                    blurred_value
);

	logic                           mode_q;
	logic [sbb_pkg::CFG_CH_W-1:0]   chan_q;
	sbb_pkg::chan_t                 chan_eff;

	logic                           valid_s1;
	sbb_pkg::pix_t                  p0_s1, p1_s1, p2_s1, p3_s1, p4_s1;
	logic                           start_s1;

	sbb_pkg::sum_t                  col_sum;
	sbb_pkg::win_view_t             view;
	logic                           full;
	sbb_pkg::pix_t                  value;
	logic                           produce;
	logic                           advance;

	logic                           out_valid_q;
	sbb_pkg::pix_t                  value_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			chan_q <= sbb_pkg::CFG_CH_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[sbb_pkg::APB_AW-1])
				sbb_pkg::REG_MODE: mode_q <= pwdata[0];
				sbb_pkg::REG_CHAN: chan_q <= pwdata[sbb_pkg::CFG_CH_W-1:0];
				default:           mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[sbb_pkg::APB_AW-1])
			sbb_pkg::REG_MODE: prdata[0] = mode_q;
			sbb_pkg::REG_CHAN: prdata[sbb_pkg::CFG_CH_W-1:0] = chan_q;
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		if (int'(chan_q) < 1) begin
			chan_eff = sbb_pkg::ECH_W'(1);
		end else if (int'(chan_q) > sbb_pkg::MAX_CHANNELS) begin
			chan_eff = sbb_pkg::ECH_W'(sbb_pkg::MAX_CHANNELS);
		end else begin
			chan_eff = sbb_pkg::ECH_W'(chan_q);
		end
	end

	// input register
	assign produce  = valid_s1 && full;
	assign advance  = valid_s1 && (!produce || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p0_s1    <= pix_row0;
			p1_s1    <= pix_row1;
			p2_s1    <= pix_row2;
			p3_s1    <= pix_row3;
			p4_s1    <= pix_row4;
			start_s1 <= row_start;
		end
	end

	sbb_col_sum u_col_sum (
		.five_tap (mode_q),
		.p0       (p0_s1),
		.p1       (p1_s1),
		.p2       (p2_s1),
		.p3       (p3_s1),
		.p4       (p4_s1),
		.sum      (col_sum)
	);

	sbb_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.row_start (start_s1),
		.sum       (col_sum),
		.chan      (chan_eff),
		.view      (view)
	);

	sbb_hpass u_hpass (
		.five_tap (mode_q),
		.chan     (chan_eff),
		.sum      (col_sum),
		.view     (view),
		.full     (full),
		.value    (value)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			value_q <= value;
		end
	end

	assign out_valid     = out_valid_q;
	assign blurred_value = value_q;

endmodule

`default_nettype wire

### src/sbb_checker.sv
// ----------------------------------------------------------------------------
// sbb_checker
// Port-level checks of the separable binomial blur, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       psel,
	input wire logic                       penable,
	input wire logic                       pwrite,
	input wire logic [sbb_pkg::APB_AW-1:0] paddr,
	input wire logic [sbb_pkg::APB_DW-1:0] prdata,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire sbb_pkg::pix_t              blurred_value
);

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result pending during reset");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with no result pending");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blurred_value))
		else $error("stalled result dropped or changed");

	a_mode_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && !pwrite && (paddr[sbb_pkg::APB_AW-1] == sbb_pkg::REG_MODE)
		|-> prdata[sbb_pkg::APB_DW-1:1] == '0)
		else $error("mode register reads back stray bits");

	a_chan_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && !pwrite && (paddr[sbb_pkg::APB_AW-1] == sbb_pkg::REG_CHAN)
		|-> prdata[sbb_pkg::APB_DW-1:sbb_pkg::CFG_CH_W] == '0)
		else $error("channel register reads back stray bits");

endmodule

bind separable_binomial_blur sbb_checker u_sbb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.prdata        (prdata),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.blurred_value (blurred_value)
);

`default_nettype wire
